### rtl/tvnh_pkg.sv
package tvnh_pkg;

    localparam int FRAC_BITS = 16;

    localparam int ROW_W   = 16;
    localparam int FREQ_W  = 24;
    localparam int ELEV_W  = 28;
    localparam int STEPS_W = 16;
    localparam int COORD_W = ROW_W + FREQ_W;
    localparam int IDX_W   = 32;
    localparam int WFRAC_W = 16;
    localparam int W_W     = 25;
    localparam int Q_W     = ELEV_W + STEPS_W;
    localparam int Q_HALF  = Q_W / 2;

    localparam int NOISE_W  = 32;
    localparam int LEVEL_W  = 30;
    localparam int HEIGHT_W = 30;
    localparam int LVL_W    = 29;

    localparam int DIV_STEP   = 8;
    localparam int DIV_STAGES = 6;
    localparam int DIV_W      = DIV_STEP * DIV_STAGES;
    localparam int DVS_W      = STEPS_W + 1;

    localparam int PIPE_DEPTH = 11 + DIV_STAGES;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_FREQUENCY     = 2'd0;
    localparam logic [1:0] REG_ELEVATION     = 2'd1;
    localparam logic [1:0] REG_TERRACE_STEPS = 2'd2;

    localparam logic [FREQ_W-1:0]  FREQUENCY_RST = FREQ_W'(6554);
    localparam logic [ELEV_W-1:0]  ELEVATION_RST = ELEV_W'(655360);
    localparam logic [STEPS_W-1:0] STEPS_RST     = STEPS_W'(1);

    localparam logic [IDX_W-1:0] HASH_Z_MUL = 32'd57;
    localparam int               HASH_SHIFT = 13;
    localparam logic [IDX_W-1:0] HASH_C1    = 32'd15731;
    localparam logic [IDX_W-1:0] HASH_C2    = 32'd789221;
    localparam logic [IDX_W-1:0] HASH_C3    = 32'd1376312589;
    localparam logic [IDX_W-1:0] HASH_MASK  = 32'h7fffffff;
    localparam logic signed [NOISE_W-1:0] NOISE_ONE = 32'sh40000000;

    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [DIV_W-1:0] work;
    } div_state_t;

endpackage

### rtl/tvnh_hash.sv
module tvnh_hash import tvnh_pkg::*; (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic [IDX_W-1:0]          x,
    input  logic [IDX_W-1:0]          z,
    output logic signed [NOISE_W-1:0] value
);

    logic [IDX_W-1:0] n_reg, sq_reg, nd1_reg, p_reg, nd2_reg;
    logic signed [NOISE_W-1:0] value_reg;
    logic [IDX_W-1:0] n_next, n0, sq_next, p_next, t_next;
    logic signed [NOISE_W-1:0] value_next;

    always_comb begin
        n0         = x + z * HASH_Z_MUL;
        n_next     = (n0 << HASH_SHIFT) ^ n0;
        sq_next    = n_reg * n_reg;
        p_next     = sq_reg * HASH_C1 + HASH_C2;
        t_next     = (nd2_reg * p_reg + HASH_C3) & HASH_MASK;
        value_next = NOISE_ONE - $signed(t_next);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_reg     <= n_next;
            sq_reg    <= sq_next;
            nd1_reg   <= n_reg;
            p_reg     <= p_next;
            nd2_reg   <= nd1_reg;
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

### rtl/tvnh_div.sv
module tvnh_div import tvnh_pkg::*; (
    input  logic                aclk,
    input  logic                ce,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    output logic [HEIGHT_W-1:0] quotient
);

    div_state_t st_reg [DIV_STAGES];
    div_state_t st_next [DIV_STAGES];

    function automatic div_state_t div_steps(div_state_t st, logic [DVS_W-1:0] d);
        logic [DVS_W:0] r;
        div_state_t     o;
        o = st;
        for (int k = 0; k < DIV_STEP; k++) begin
            r      = {o.rem, o.work[DIV_W-1]};
            o.work = {o.work[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r         = r - {1'b0, d};
                o.work[0] = 1'b1;
            end
            o.rem = r[DVS_W-1:0];
        end
        return o;
    endfunction

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb begin
                st_next[s] = div_steps('{rem: '0, work: dividend}, divisor);
            end
        end else begin : g_rest
            always_comb begin
                st_next[s] = div_steps(st_reg[s-1], divisor);
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign quotient = st_reg[DIV_STAGES-1].work[HEIGHT_W-1:0];

endmodule

### rtl/terraced_value_noise_height.sv
// Terraced value-noise height generator. Each transfer on the s_ channel carries one grid
// sample (row, column); each transfer on the m_ channel returns its noise value (Q2.30),
// terrace level and height (Q16.16), in input order. The block takes one sample per clock
// while the output is not stalled. A sample passes through 17 register stages before its
// result is offered on m_tvalid: ten arithmetic stages (coordinate multiply, four-stage
// lattice hash, corner smoothing, two blend stages, level multiply and round), then a
// six-stage restoring divider for the height with eight quotient bits per stage, and the
// output register. All stages advance together while the output register is empty or
// being taken, so s_tready follows m_tready whenever a result is waiting. Registers
// (frequency, elevation, terrace_steps at 0x0, 0x4, 0x8) must only be written when idle.
module terraced_value_noise_height import tvnh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // grid_row [15:0], grid_col [31:16]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // noise_value [31:0], terrace_level [61:32],
                                         // height [91:62], zero [95:92]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [FREQ_W-1:0]  frequency_reg;
    logic [ELEV_W-1:0]  elevation_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [STEPS_W-1:0] steps_eff;
    logic [Q_W-1:0]     q_reg;
    logic               cfg_wr;
    logic               ce;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic [COORD_W-1:0] cx_reg [2];
    logic [IDX_W-1:0]   base_idx [2];
    logic [WFRAC_W-1:0] a_reg [2];
    logic [2*WFRAC_W-1:0] a2_reg [2];
    logic [WFRAC_W-1:0] ad_reg [2];
    logic [3*WFRAC_W-1:0] a3_reg [2];
    logic [3*WFRAC_W+1:0] t3_reg [2];
    logic [W_W-1:0]     w_reg [2];
    logic [W_W-1:0]     wd_reg [2];
    logic [W_W-1:0]     wz2_reg;

    logic signed [NOISE_W-1:0] lat [4][4];
    logic signed [NOISE_W-1:0] corner_reg [2][2];
    logic signed [NOISE_W-1:0] v_reg [2];
    logic signed [NOISE_W-1:0] noise_reg;
    logic signed [NOISE_W-1:0] noise9_reg;
    logic                      neg9_reg;
    logic [NOISE_W-2:0]        mag;
    logic [NOISE_W-2+Q_HALF:0] hi_reg, lo_reg;
    logic [NOISE_W+Q_W-1:0]    total;
    logic [LVL_W-1:0]          lvl10_reg;
    logic                      neg10_reg;
    logic signed [NOISE_W-1:0] noise10_reg;

    logic [LVL_W-1:0]          dly_lvl_reg [DIV_STAGES];
    logic                      dly_neg_reg [DIV_STAGES];
    logic signed [NOISE_W-1:0] dly_noise_reg [DIV_STAGES];
    logic [HEIGHT_W-1:0]       quotient;

    logic [NOISE_W-1:0]  out_noise_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [HEIGHT_W-1:0] out_height_reg;

    function automatic logic [WFRAC_W-1:0] frac16(logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS+23:0] t;
        t = {f, 24'b0};
        return WFRAC_W'(t >> (FRAC_BITS + 8));
    endfunction

    function automatic logic signed [NOISE_W-1:0] blend(logic signed [NOISE_W-1:0] a,
                                                        logic signed [NOISE_W-1:0] b,
                                                        logic [W_W-1:0] w);
        logic [W_W-1:0]     wc;
        logic signed [58:0] s;
        wc = W_W'(1 << 24) - w;
        s  = a * $signed({1'b0, wc}) + b * $signed({1'b0, w}) + 59'sd8388608;
        return s[55:24];
    endfunction

    function automatic logic signed [NOISE_W-1:0] smooth9(
        logic signed [NOISE_W-1:0] d0, logic signed [NOISE_W-1:0] d1,
        logic signed [NOISE_W-1:0] d2, logic signed [NOISE_W-1:0] d3,
        logic signed [NOISE_W-1:0] s0, logic signed [NOISE_W-1:0] s1,
        logic signed [NOISE_W-1:0] s2, logic signed [NOISE_W-1:0] s3,
        logic signed [NOISE_W-1:0] c);
        logic signed [35:0] sum;
        sum = 36'(d0) + 36'(d1) + 36'(d2) + 36'(d3)
            + ((36'(s0) + 36'(s1) + 36'(s2) + 36'(s3)) <<< 1)
            + (36'(c) <<< 2) + 36'sd8;
        return sum[35:4];
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frequency_reg <= FREQUENCY_RST;
            elevation_reg <= ELEVATION_RST;
            steps_reg     <= STEPS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FREQUENCY:     frequency_reg <= pwdata[FREQ_W-1:0];
                REG_ELEVATION:     elevation_reg <= pwdata[ELEV_W-1:0];
                REG_TERRACE_STEPS: steps_reg     <= pwdata[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FREQUENCY:     prdata = DATA_W'(frequency_reg);
            REG_ELEVATION:     prdata = DATA_W'(elevation_reg);
            REG_TERRACE_STEPS: prdata = DATA_W'(steps_reg);
            default:           prdata = '0;
        endcase
    end

    assign steps_eff = (steps_reg == '0) ? STEPS_W'(1) : steps_reg;

    always_ff @(posedge aclk) begin
        q_reg <= Q_W'(elevation_reg) * Q_W'(steps_eff);
    end

    assign ce       = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    for (genvar k = 0; k < 2; k++) begin : g_axis
        assign base_idx[k] = IDX_W'(cx_reg[k] >> FRAC_BITS);
        always_ff @(posedge aclk) begin
            if (ce) begin
                cx_reg[k] <= COORD_W'(s_tdata[k*ROW_W +: ROW_W]) * COORD_W'(frequency_reg);
                a_reg[k]  <= frac16(cx_reg[k][FRAC_BITS-1:0]);
                a2_reg[k] <= (2*WFRAC_W)'(a_reg[k]) * (2*WFRAC_W)'(a_reg[k]);
                ad_reg[k] <= a_reg[k];
                a3_reg[k] <= (3*WFRAC_W)'(a2_reg[k]) * (3*WFRAC_W)'(ad_reg[k]);
                t3_reg[k] <= ((3*WFRAC_W+2)'(a2_reg[k]) * (3*WFRAC_W+2)'(3)) << WFRAC_W;
                w_reg[k]  <= W_W'((t3_reg[k] - (3*WFRAC_W+2)'({a3_reg[k], 1'b0})
                                   + (3*WFRAC_W+2)'(1 << 23)) >> 24);
                wd_reg[k] <= w_reg[k];
            end
        end
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_lx
        for (genvar gj = 0; gj < 4; gj++) begin : g_lz
            tvnh_hash u_hash (
                .aclk  (aclk),
                .ce    (ce),
                .x     (base_idx[0] + IDX_W'(gi) - IDX_W'(1)),
                .z     (base_idx[1] + IDX_W'(gj) - IDX_W'(1)),
                .value (lat[gi][gj])
            );
        end
    end

    for (genvar ca = 0; ca < 2; ca++) begin : g_ca
        for (genvar cb = 0; cb < 2; cb++) begin : g_cb
            always_ff @(posedge aclk) begin
                if (ce) begin
                    corner_reg[ca][cb] <= smooth9(
                        lat[ca][cb], lat[ca+2][cb], lat[ca][cb+2], lat[ca+2][cb+2],
                        lat[ca][cb+1], lat[ca+2][cb+1], lat[ca+1][cb], lat[ca+1][cb+2],
                        lat[ca+1][cb+1]);
                end
            end
        end
    end

    assign mag   = (NOISE_W-1)'(noise_reg[NOISE_W-1] ? -noise_reg : noise_reg);
    assign total = ((NOISE_W+Q_W)'(hi_reg) << Q_HALF) + (NOISE_W+Q_W)'(lo_reg)
                 + ((NOISE_W+Q_W)'(1) << 45);

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg[0]    <= blend(corner_reg[0][0], corner_reg[1][0], wd_reg[0]);
            v_reg[1]    <= blend(corner_reg[0][1], corner_reg[1][1], wd_reg[0]);
            wz2_reg     <= wd_reg[1];
            noise_reg   <= blend(v_reg[0], v_reg[1], wz2_reg);
            hi_reg      <= (NOISE_W-1+Q_HALF)'(mag) * (NOISE_W-1+Q_HALF)'(q_reg[Q_W-1:Q_HALF]);
            lo_reg      <= (NOISE_W-1+Q_HALF)'(mag) * (NOISE_W-1+Q_HALF)'(q_reg[Q_HALF-1:0]);
            neg9_reg    <= noise_reg[NOISE_W-1];
            noise9_reg  <= noise_reg;
            lvl10_reg   <= LVL_W'(total >> 46);
            neg10_reg   <= neg9_reg;
            noise10_reg <= noise9_reg;
        end
    end

    tvnh_div u_div (
        .aclk     (aclk),
        .ce       (ce),
        .dividend (DIV_W'({lvl10_reg, 1'b0, steps_eff})),
        .divisor  ({steps_eff, 1'b0}),
        .quotient (quotient)
    );

    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (d == 0) begin
                    dly_lvl_reg[d]   <= lvl10_reg;
                    dly_neg_reg[d]   <= neg10_reg;
                    dly_noise_reg[d] <= noise10_reg;
                end else begin
                    dly_lvl_reg[d]   <= dly_lvl_reg[d-1];
                    dly_neg_reg[d]   <= dly_neg_reg[d-1];
                    dly_noise_reg[d] <= dly_noise_reg[d-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_noise_reg  <= dly_noise_reg[DIV_STAGES-1];
            out_level_reg  <= dly_neg_reg[DIV_STAGES-1]
                            ? -LEVEL_W'(dly_lvl_reg[DIV_STAGES-1])
                            :  LEVEL_W'(dly_lvl_reg[DIV_STAGES-1]);
            out_height_reg <= dly_neg_reg[DIV_STAGES-1] ? -quotient : quotient;
        end
    end

    assign m_tdata = {4'b0, out_height_reg, out_level_reg, out_noise_reg};

endmodule

### rtl/tvnh_checker.sv
module tvnh_checker import tvnh_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [95:0]       m_tdata
);

    logic signed [NOISE_W-1:0] noise;
    assign noise = $signed(m_tdata[31:0]);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_noise_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (noise <= NOISE_ONE) && (noise >= -NOISE_ONE))
        else $error("noise outside [-1, 1]");

    a_zero_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[61:32] == '0) |-> (m_tdata[91:62] == '0))
        else $error("zero level with nonzero height");

    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline frozen");

endmodule

bind terraced_value_noise_height tvnh_checker u_tvnh_checker (.*);
